/* rtl/scara_inverse_dynamics_torque_assert.svh */
`ifndef SCARA_INVERSE_DYNAMICS_TORQUE_ASSERT_SVH
`define SCARA_INVERSE_DYNAMICS_TORQUE_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SIDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that a condition holds in the cycle after its trigger.
`define SIDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/scara_idt_pkg.sv */
`timescale 1ns / 1ps
package scara_idt_pkg;

    localparam int WordW     = 24;
    localparam int AngW      = 15;
    localparam int CfgW      = 24;
    localparam int CfgIdxW   = 3;
    localparam int CordW     = 20;
    localparam int CordSteps = 16;
    localparam int DynStages = 4;

    localparam logic signed [16:0] PiQ12     = 17'sd12868;
    localparam logic signed [16:0] HalfPiQ12 = 17'sd6434;
    localparam logic signed [16:0] TwoPiQ12  = 17'sd25736;

    localparam logic signed [CordW-1:0] CordGain = 20'sd39797;
    localparam logic signed [CordW-1:0] CordZTol = 20'sd256;

    localparam logic signed [63:0] Lim32Hi = 64'sd2147483647;
    localparam logic signed [63:0] Lim32Lo = -64'sd2147483648;
    localparam logic signed [63:0] WordHi  = (64'sd1 <<< (WordW - 1)) - 64'sd1;
    localparam logic signed [63:0] WordLo  = -(64'sd1 <<< (WordW - 1));

    localparam logic [CfgW-1:0] CfgRstMassOne   = 24'd65536;
    localparam logic [CfgW-1:0] CfgRstMassTwo   = 24'd176947;
    localparam logic [CfgW-1:0] CfgRstLenOne    = 24'd12780;
    localparam logic [CfgW-1:0] CfgRstLenTwo    = 24'd9306;
    localparam logic [CfgW-1:0] CfgRstMassWrist = 24'd65536;
    localparam logic [CfgW-1:0] CfgRstRadWrist  = 24'd1966;
    localparam logic signed [CfgW-1:0] CfgRstGravity = -24'sd642908;

    typedef enum logic [CfgIdxW-1:0] {
        CfgMassLinkOne   = 3'd0,
        CfgMassLinkTwo   = 3'd1,
        CfgLengthLinkOne = 3'd2,
        CfgLengthLinkTwo = 3'd3,
        CfgMassWrist     = 3'd4,
        CfgRadiusWrist   = 3'd5,
        CfgGravityAccel  = 3'd6
    } t_cfg_idx;

    typedef logic signed [WordW-1:0] t_word;
    typedef logic signed [31:0] t_q32;

    typedef struct packed {
        t_q32 v;
        logic f;
    } t_qf;

    typedef struct packed {
        t_word v;
        logic  f;
    } t_wf;

    typedef struct packed {
        t_word shoulder_rate;
        t_word elbow_rate;
        t_word shoulder_accel;
        t_word elbow_accel;
        t_word lift_accel;
        t_word wrist_accel;
    } t_joint;

    typedef struct packed {
        logic signed [CordW-1:0] sin_v;
        logic signed [CordW-1:0] cos_v;
        t_joint                  j;
    } t_trig;

    typedef struct packed {
        t_q32                   h;
        t_q32                   p;
        t_q32                   q;
        t_q32                   kw;
        logic [CfgW-1:0]        m2;
        logic signed [CfgW-1:0] g;
        logic                   f;
    } t_coef;

    function automatic t_qf clamp32(input logic signed [63:0] v);
        t_qf r;
        r.f = (v > Lim32Hi) || (v < Lim32Lo);
        if (v > Lim32Hi) begin
            r.v = 32'(Lim32Hi);
        end else if (v < Lim32Lo) begin
            r.v = 32'(Lim32Lo);
        end else begin
            r.v = 32'(v);
        end
        return r;
    endfunction

    function automatic t_wf sat_word(input logic signed [63:0] v);
        t_wf r;
        r.f = (v > WordHi) || (v < WordLo);
        if (v > WordHi) begin
            r.v = WordW'(WordHi);
        end else if (v < WordLo) begin
            r.v = WordW'(WordLo);
        end else begin
            r.v = WordW'(v);
        end
        return r;
    endfunction

    function automatic t_qf rnd_sh(input logic signed [63:0] prod, input int unsigned sh);
        logic signed [63:0] t;
        t = (prod + (64'sd1 <<< (sh - 1))) >>> sh;
        return clamp32(t);
    endfunction

    function automatic t_qf word_op(input t_word a);
        return clamp32(64'(a));
    endfunction

    function automatic logic signed [63:0] ucfg(input logic [CfgW-1:0] a);
        return $signed(64'(a));
    endfunction

    function automatic logic signed [63:0] mul32(input t_q32 a, input t_q32 b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic logic signed [CordW-1:0] atan_q16(input int unsigned i);
        logic signed [CordW-1:0] r;
        case (i)
            0:       r = 20'sd51472;
            1:       r = 20'sd30385;
            2:       r = 20'sd16055;
            3:       r = 20'sd8150;
            4:       r = 20'sd4091;
            5:       r = 20'sd2047;
            6:       r = 20'sd1024;
            7:       r = 20'sd512;
            8:       r = 20'sd256;
            9:       r = 20'sd128;
            10:      r = 20'sd64;
            11:      r = 20'sd32;
            12:      r = 20'sd16;
            13:      r = 20'sd8;
            14:      r = 20'sd4;
            15:      r = 20'sd2;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/scara_idt_coef.sv */
`timescale 1ns / 1ps
module scara_idt_coef (
    input  logic                                      i_clk,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_mass_one,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_mass_two,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_len_one,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_len_two,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_mass_wrist,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_rad_wrist,
    input  logic signed [scara_idt_pkg::CfgW-1:0]     i_gravity,
    output scara_idt_pkg::t_coef                      o_coef
);

    scara_idt_pkg::t_qf n_hm, n_pm, n_qm, n_wm;
    scara_idt_pkg::t_qf r_hm, r_pm, r_qm, r_wm;
    scara_idt_pkg::t_qf n_h, n_p, n_q, n_kw;
    scara_idt_pkg::t_qf r_h, r_p, r_q, r_kw;
    logic               r_f;

    always_comb begin
        n_hm = scara_idt_pkg::rnd_sh(
            scara_idt_pkg::ucfg(i_mass_two) * scara_idt_pkg::ucfg(i_len_one), 16);
        n_pm = scara_idt_pkg::rnd_sh(
            scara_idt_pkg::ucfg(i_mass_two) * scara_idt_pkg::ucfg(i_len_two), 16);
        n_qm = scara_idt_pkg::rnd_sh(
            (scara_idt_pkg::ucfg(i_mass_one) + scara_idt_pkg::ucfg(i_mass_two))
            * scara_idt_pkg::ucfg(i_len_one), 16);
        n_wm = scara_idt_pkg::rnd_sh(
            scara_idt_pkg::ucfg(i_mass_wrist) * scara_idt_pkg::ucfg(i_rad_wrist), 16);
    end

    always_ff @(posedge i_clk) begin
        r_hm <= n_hm;
        r_pm <= n_pm;
        r_qm <= n_qm;
        r_wm <= n_wm;
    end

    always_comb begin
        n_h  = scara_idt_pkg::rnd_sh(64'(r_hm.v) * scara_idt_pkg::ucfg(i_len_two), 16);
        n_p  = scara_idt_pkg::rnd_sh(64'(r_pm.v) * scara_idt_pkg::ucfg(i_len_two), 16);
        n_q  = scara_idt_pkg::rnd_sh(64'(r_qm.v) * scara_idt_pkg::ucfg(i_len_one), 16);
        n_kw = scara_idt_pkg::rnd_sh(64'(r_wm.v) * scara_idt_pkg::ucfg(i_rad_wrist), 16);
    end

    always_ff @(posedge i_clk) begin
        r_h  <= n_h;
        r_p  <= n_p;
        r_q  <= n_q;
        r_kw <= n_kw;
        r_f  <= r_hm.f | r_pm.f | r_qm.f | r_wm.f | n_h.f | n_p.f | n_q.f | n_kw.f;
    end

    always_comb begin
        o_coef.h  = r_h.v;
        o_coef.p  = r_p.v;
        o_coef.q  = r_q.v;
        o_coef.kw = r_kw.v;
        o_coef.m2 = i_mass_two;
        o_coef.g  = i_gravity;
        o_coef.f  = r_f;
    end

endmodule

/* rtl/scara_idt_cordic.sv */
`timescale 1ns / 1ps
`include "scara_inverse_dynamics_torque_assert.svh"
module scara_idt_cordic (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic signed [scara_idt_pkg::AngW-1:0]     i_angle,
    input  scara_idt_pkg::t_joint                     i_joint,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output scara_idt_pkg::t_trig                      o_item
);

    logic [scara_idt_pkg::CordSteps:0]          r_v;
    logic [scara_idt_pkg::CordSteps:0]          adv;
    logic signed [scara_idt_pkg::CordW-1:0]     r_x [0:scara_idt_pkg::CordSteps];
    logic signed [scara_idt_pkg::CordW-1:0]     r_y [0:scara_idt_pkg::CordSteps];
    logic signed [scara_idt_pkg::CordW-1:0]     r_z [0:scara_idt_pkg::CordSteps];
    logic                                       r_neg [0:scara_idt_pkg::CordSteps];
    scara_idt_pkg::t_joint                      r_j [0:scara_idt_pkg::CordSteps];

    logic signed [16:0]                         a_ext, a_w1, a_w2, a_f;
    logic                                       n_neg;
    logic signed [scara_idt_pkg::CordW-1:0]     n_z0;

    // A stage moves on unless it and every stage after it hold an item and the
    // output is stalled.
    always_comb begin
        for (int k = 0; k <= scara_idt_pkg::CordSteps; k++) begin
            adv[k] = i_ready ||
                     ((r_v >> k) != ({(scara_idt_pkg::CordSteps + 1){1'b1}} >> k));
        end
    end

    always_comb begin
        a_ext = 17'(i_angle);
        a_w1  = (a_ext > scara_idt_pkg::PiQ12) ? a_ext - scara_idt_pkg::TwoPiQ12 : a_ext;
        a_w2  = (a_w1 < -scara_idt_pkg::PiQ12) ? a_w1 + scara_idt_pkg::TwoPiQ12 : a_w1;
        if (a_w2 > scara_idt_pkg::HalfPiQ12) begin
            a_f   = a_w2 - scara_idt_pkg::PiQ12;
            n_neg = 1'b1;
        end else if (a_w2 < -scara_idt_pkg::HalfPiQ12) begin
            a_f   = a_w2 + scara_idt_pkg::PiQ12;
            n_neg = 1'b1;
        end else begin
            a_f   = a_w2;
            n_neg = 1'b0;
        end
        n_z0 = scara_idt_pkg::CordW'(a_f) <<< 4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= scara_idt_pkg::CordSteps; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_x[0]   <= scara_idt_pkg::CordGain;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg;
            r_j[0]   <= i_joint;
        end
    end

    for (genvar i = 0; i < scara_idt_pkg::CordSteps; i++) begin : g_iter
        logic signed [scara_idt_pkg::CordW-1:0] n_x, n_y, n_z;

        always_comb begin
            if (r_z[i] >= 0) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - scara_idt_pkg::atan_q16(i);
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + scara_idt_pkg::atan_q16(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[i+1]) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_neg[i+1] <= r_neg[i];
                r_j[i+1]   <= r_j[i];
            end
        end
    end

    always_comb begin
        o_valid      = r_v[scara_idt_pkg::CordSteps];
        o_ready      = adv[0];
        o_item.sin_v = r_neg[scara_idt_pkg::CordSteps] ? -r_y[scara_idt_pkg::CordSteps]
                                                       : r_y[scara_idt_pkg::CordSteps];
        o_item.cos_v = r_neg[scara_idt_pkg::CordSteps] ? -r_x[scara_idt_pkg::CordSteps]
                                                       : r_x[scara_idt_pkg::CordSteps];
        o_item.j     = r_j[scara_idt_pkg::CordSteps];
    end

    `SIDT_ASSERT_NEXT(a_last_held, i_clk, i_rst_n, r_v[scara_idt_pkg::CordSteps] && !i_ready, r_v[scara_idt_pkg::CordSteps])
    `SIDT_ASSERT_NOW(a_full_when_blocked, i_clk, i_rst_n, !adv[0], r_v[0] && r_v[scara_idt_pkg::CordSteps])
    `SIDT_ASSERT_NOW(a_angle_converged, i_clk, i_rst_n, r_v[scara_idt_pkg::CordSteps], (r_z[scara_idt_pkg::CordSteps] <= scara_idt_pkg::CordZTol) && (r_z[scara_idt_pkg::CordSteps] >= -scara_idt_pkg::CordZTol))

endmodule

/* rtl/scara_idt_dyn.sv */
`timescale 1ns / 1ps
module scara_idt_dyn (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  scara_idt_pkg::t_trig                  i_item,
    input  scara_idt_pkg::t_coef                  i_coef,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output scara_idt_pkg::t_word                  o_shoulder_torque,
    output scara_idt_pkg::t_word                  o_elbow_torque,
    output scara_idt_pkg::t_word                  o_lift_force,
    output scara_idt_pkg::t_word                  o_wrist_torque,
    output logic                                  o_saturated
);

    logic [scara_idt_pkg::DynStages-1:0] r_v;
    logic [scara_idt_pkg::DynStages-1:0] adv;

    scara_idt_pkg::t_qf n_cw1, n_cw2, n_ca1, n_ca2, n_cal, n_caw;
    scara_idt_pkg::t_qf n_hc, n_hs, n_ww11, n_ww12, n_ww22, n_lg, n_la, n_wt;
    logic               n0_f;
    scara_idt_pkg::t_q32 r0_hc, r0_hs, r0_ww11, r0_ww12, r0_ww22, r0_lg, r0_la, r0_wt;
    scara_idt_pkg::t_q32 r0_a1, r0_a2;
    logic               r0_f;

    scara_idt_pkg::t_qf n_m11, n_m12;
    scara_idt_pkg::t_q32 r1_m11, r1_m12, r1_hs, r1_ww11, r1_ww12, r1_ww22, r1_a1, r1_a2;
    scara_idt_pkg::t_q32 r1_wt;
    logic signed [32:0] r1_t2;
    logic               r1_f;

    scara_idt_pkg::t_qf n_e1, n_e2, n_e3, n_e4, n_e5, n_e6, n_e7;
    scara_idt_pkg::t_q32 r2_e1, r2_e2, r2_e3, r2_e4, r2_e5, r2_e6, r2_e7, r2_wt;
    logic signed [32:0] r2_t2;
    logic               r2_f;

    scara_idt_pkg::t_wf n_s0, n_s1, n_s2, n_s3;
    scara_idt_pkg::t_word r_out_t0, r_out_t1, r_out_t2, r_out_t3;
    logic               r_out_sat;

    always_comb begin
        for (int k = 0; k < scara_idt_pkg::DynStages; k++) begin
            adv[k] = !i_stall ||
                     ((r_v >> k) != ({scara_idt_pkg::DynStages{1'b1}} >> k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < scara_idt_pkg::DynStages; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        n_cw1  = scara_idt_pkg::word_op(i_item.j.shoulder_rate);
        n_cw2  = scara_idt_pkg::word_op(i_item.j.elbow_rate);
        n_ca1  = scara_idt_pkg::word_op(i_item.j.shoulder_accel);
        n_ca2  = scara_idt_pkg::word_op(i_item.j.elbow_accel);
        n_cal  = scara_idt_pkg::word_op(i_item.j.lift_accel);
        n_caw  = scara_idt_pkg::word_op(i_item.j.wrist_accel);
        n_hc   = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(i_coef.h, 32'(i_item.cos_v)), 16);
        n_hs   = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(i_coef.h, 32'(i_item.sin_v)), 16);
        n_ww11 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(n_cw1.v, n_cw1.v), 12);
        n_ww12 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(n_cw1.v, n_cw2.v), 12);
        n_ww22 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(n_cw2.v, n_cw2.v), 12);
        n_lg   = scara_idt_pkg::rnd_sh(scara_idt_pkg::ucfg(i_coef.m2) * 64'(i_coef.g), 20);
        n_la   = scara_idt_pkg::rnd_sh(scara_idt_pkg::ucfg(i_coef.m2) * 64'(n_cal.v), 16);
        n_wt   = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(i_coef.kw, n_caw.v), 16);
        n0_f   = i_coef.f | n_cw1.f | n_cw2.f | n_ca1.f | n_ca2.f | n_cal.f | n_caw.f
               | n_hc.f | n_hs.f | n_ww11.f | n_ww12.f | n_ww22.f | n_lg.f | n_la.f
               | n_wt.f;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_hc   <= n_hc.v;
            r0_hs   <= n_hs.v;
            r0_ww11 <= n_ww11.v;
            r0_ww12 <= n_ww12.v;
            r0_ww22 <= n_ww22.v;
            r0_lg   <= n_lg.v;
            r0_la   <= n_la.v;
            r0_wt   <= n_wt.v;
            r0_a1   <= n_ca1.v;
            r0_a2   <= n_ca2.v;
            r0_f    <= n0_f;
        end
    end

    always_comb begin
        n_m11 = scara_idt_pkg::clamp32(64'(i_coef.p) + 64'sd2 * 64'(r0_hc) + 64'(i_coef.q));
        n_m12 = scara_idt_pkg::clamp32(64'(i_coef.p) + 64'(r0_hc));
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_m11  <= n_m11.v;
            r1_m12  <= n_m12.v;
            r1_hs   <= r0_hs;
            r1_ww11 <= r0_ww11;
            r1_ww12 <= r0_ww12;
            r1_ww22 <= r0_ww22;
            r1_a1   <= r0_a1;
            r1_a2   <= r0_a2;
            r1_wt   <= r0_wt;
            r1_t2   <= 33'(r0_lg) + 33'(r0_la);
            r1_f    <= r0_f | n_m11.f | n_m12.f;
        end
    end

    always_comb begin
        n_e1 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(r1_m11, r1_a1), 16);
        n_e2 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(r1_m12, r1_a2), 16);
        n_e3 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(r1_hs, r1_ww22), 16);
        n_e4 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(r1_hs, r1_ww12), 16);
        n_e5 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(r1_m12, r1_a1), 16);
        n_e6 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(i_coef.p, r1_a2), 16);
        n_e7 = scara_idt_pkg::rnd_sh(scara_idt_pkg::mul32(r1_hs, r1_ww11), 16);
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_e1 <= n_e1.v;
            r2_e2 <= n_e2.v;
            r2_e3 <= n_e3.v;
            r2_e4 <= n_e4.v;
            r2_e5 <= n_e5.v;
            r2_e6 <= n_e6.v;
            r2_e7 <= n_e7.v;
            r2_wt <= r1_wt;
            r2_t2 <= r1_t2;
            r2_f  <= r1_f | n_e1.f | n_e2.f | n_e3.f | n_e4.f | n_e5.f | n_e6.f | n_e7.f;
        end
    end

    always_comb begin
        n_s0 = scara_idt_pkg::sat_word(64'(r2_e1) + 64'(r2_e2) - 64'(r2_e3)
                                       - 64'sd2 * 64'(r2_e4));
        n_s1 = scara_idt_pkg::sat_word(64'(r2_e5) + 64'(r2_e6) + 64'(r2_e7));
        n_s2 = scara_idt_pkg::sat_word(64'(r2_t2));
        n_s3 = scara_idt_pkg::sat_word(64'(r2_wt));
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_out_t0  <= n_s0.v;
            r_out_t1  <= n_s1.v;
            r_out_t2  <= n_s2.v;
            r_out_t3  <= n_s3.v;
            r_out_sat <= r2_f | n_s0.f | n_s1.f | n_s2.f | n_s3.f;
        end
    end

    always_comb begin
        o_ready           = adv[0];
        o_valid           = r_v[scara_idt_pkg::DynStages-1];
        o_shoulder_torque = r_out_t0;
        o_elbow_torque    = r_out_t1;
        o_lift_force      = r_out_t2;
        o_wrist_torque    = r_out_t3;
        o_saturated       = r_out_sat;
    end

endmodule

/* rtl/scara_inverse_dynamics_torque.sv */
// Inverse dynamics for a four-joint arm with two planar links, a vertical lift and a
// wrist rotor. Each item carries the elbow angle (Q3.12) and the joint rates and
// accelerations (Q12.12); each result carries the four joint torques (Q12.12) and a
// flag that is set when any intermediate value or output was clipped. One item is
// accepted per clock while o_stall is low; each passes a fold stage and sixteen CORDIC
// stages for the elbow sine and cosine, then four arithmetic stages ending in the
// output register. Write the arm constants (Q8.16) only while no item is in flight;
// the block does not enforce this. They apply to every item accepted after the write.
`timescale 1ns / 1ps
module scara_inverse_dynamics_torque (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [scara_idt_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [scara_idt_pkg::CfgW-1:0]            i_cfg_data,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [scara_idt_pkg::AngW-1:0]     i_elbow_angle,
    input  logic signed [scara_idt_pkg::WordW-1:0]    i_shoulder_rate,
    input  logic signed [scara_idt_pkg::WordW-1:0]    i_elbow_rate,
    input  logic signed [scara_idt_pkg::WordW-1:0]    i_shoulder_accel,
    input  logic signed [scara_idt_pkg::WordW-1:0]    i_elbow_accel,
    input  logic signed [scara_idt_pkg::WordW-1:0]    i_lift_accel,
    input  logic signed [scara_idt_pkg::WordW-1:0]    i_wrist_accel,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [scara_idt_pkg::WordW-1:0]    o_shoulder_torque,
    output logic signed [scara_idt_pkg::WordW-1:0]    o_elbow_torque,
    output logic signed [scara_idt_pkg::WordW-1:0]    o_lift_force,
    output logic signed [scara_idt_pkg::WordW-1:0]    o_wrist_torque,
    output logic                                      o_saturated
);

    logic [scara_idt_pkg::CfgW-1:0]        r_mass_one, r_mass_two, r_len_one, r_len_two;
    logic [scara_idt_pkg::CfgW-1:0]        r_mass_wrist, r_rad_wrist;
    logic signed [scara_idt_pkg::CfgW-1:0] r_gravity;

    scara_idt_pkg::t_joint joint;
    scara_idt_pkg::t_coef  coef;
    scara_idt_pkg::t_trig  trig;
    logic                  cordic_ready, trig_valid, dyn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_one   <= scara_idt_pkg::CfgRstMassOne;
            r_mass_two   <= scara_idt_pkg::CfgRstMassTwo;
            r_len_one    <= scara_idt_pkg::CfgRstLenOne;
            r_len_two    <= scara_idt_pkg::CfgRstLenTwo;
            r_mass_wrist <= scara_idt_pkg::CfgRstMassWrist;
            r_rad_wrist  <= scara_idt_pkg::CfgRstRadWrist;
            r_gravity    <= scara_idt_pkg::CfgRstGravity;
        end else if (i_cfg_we) begin
            unique case (scara_idt_pkg::t_cfg_idx'(i_cfg_idx))
                scara_idt_pkg::CfgMassLinkOne:   r_mass_one   <= i_cfg_data;
                scara_idt_pkg::CfgMassLinkTwo:   r_mass_two   <= i_cfg_data;
                scara_idt_pkg::CfgLengthLinkOne: r_len_one    <= i_cfg_data;
                scara_idt_pkg::CfgLengthLinkTwo: r_len_two    <= i_cfg_data;
                scara_idt_pkg::CfgMassWrist:     r_mass_wrist <= i_cfg_data;
                scara_idt_pkg::CfgRadiusWrist:   r_rad_wrist  <= i_cfg_data;
                scara_idt_pkg::CfgGravityAccel:  r_gravity    <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        joint.shoulder_rate  = i_shoulder_rate;
        joint.elbow_rate     = i_elbow_rate;
        joint.shoulder_accel = i_shoulder_accel;
        joint.elbow_accel    = i_elbow_accel;
        joint.lift_accel     = i_lift_accel;
        joint.wrist_accel    = i_wrist_accel;
        o_stall              = !cordic_ready;
    end

    scara_idt_coef u_coef (
        .i_clk        (i_clk),
        .i_mass_one   (r_mass_one),
        .i_mass_two   (r_mass_two),
        .i_len_one    (r_len_one),
        .i_len_two    (r_len_two),
        .i_mass_wrist (r_mass_wrist),
        .i_rad_wrist  (r_rad_wrist),
        .i_gravity    (r_gravity),
        .o_coef       (coef)
    );

    scara_idt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (cordic_ready),
        .i_angle (i_elbow_angle),
        .i_joint (joint),
        .o_valid (trig_valid),
        .i_ready (dyn_ready),
        .o_item  (trig)
    );

    scara_idt_dyn u_dyn (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (trig_valid),
        .o_ready           (dyn_ready),
        .i_item            (trig),
        .i_coef            (coef),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_shoulder_torque (o_shoulder_torque),
        .o_elbow_torque    (o_elbow_torque),
        .o_lift_force      (o_lift_force),
        .o_wrist_torque    (o_wrist_torque),
        .o_saturated       (o_saturated)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;

    typedef logic signed [scara_idt_pkg::AngW-1:0] t_angle;

    typedef struct {
        t_angle angle;
        scara_idt_pkg::t_word w1, w2, a1, a2, al, aw;
    } t_arm_item;

    typedef struct {
        scara_idt_pkg::t_word shoulder, elbow, lift, wrist;
        logic  sat;
    } t_torques;

    localparam logic [scara_idt_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd7;
    localparam int NumRegs = 7;
    localparam int WatchdogLimit = 4000;
    localparam longint Q32Hi = 64'sd2147483647;
    localparam longint Q32Lo = -64'sd2147483648;
    localparam longint AtanTbl [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};
    localparam scara_idt_pkg::t_word WordMax = scara_idt_pkg::t_word'(scara_idt_pkg::WordHi);
    localparam scara_idt_pkg::t_word WordMin = scara_idt_pkg::t_word'(scara_idt_pkg::WordLo);

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [scara_idt_pkg::CfgIdxW-1:0] i_cfg_idx;
    logic [scara_idt_pkg::CfgW-1:0] i_cfg_data;
    logic i_valid, o_stall, o_valid, i_stall;
    t_angle i_elbow_angle;
    scara_idt_pkg::t_word i_shoulder_rate, i_elbow_rate, i_shoulder_accel, i_elbow_accel;
    scara_idt_pkg::t_word i_lift_accel, i_wrist_accel;
    scara_idt_pkg::t_word o_shoulder_torque, o_elbow_torque, o_lift_force, o_wrist_torque;
    logic o_saturated;

    scara_inverse_dynamics_torque dut (.*);

    t_arm_item pending_items[$];
    t_torques expected_torques[$];
    t_arm_item driven_item;
    logic [scara_idt_pkg::CfgW-1:0] arm_regs [NumRegs];
    int send_idle_pct, recv_idle_pct;
    int errors = 0;
    int quiet_cycles = 0;

    function automatic longint clip(longint v, longint lo, longint hi, inout logic f);
        if (v > hi) begin
            f = 1'b1;
            return hi;
        end
        if (v < lo) begin
            f = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b, int sh, inout logic f);
        longint p;
        a = clip(a, Q32Lo, Q32Hi, f);
        b = clip(b, Q32Lo, Q32Hi, f);
        p = a * b + (64'sd1 <<< (sh - 1));
        return clip(p >>> sh, Q32Lo, Q32Hi, f);
    endfunction

    function automatic t_torques arm_torques(t_arm_item it);
        t_torques r;
        logic f;
        longint m1, m2, l1, l2, mw, rw, g, ang, x, y, z, nx, s, c;
        longint w1, w2, h, p, q, hc, hs, m11, m12, ww11, ww12, ww22;
        longint t [4];
        logic neg;
        f = 1'b0;
        neg = 1'b0;
        m1 = longint'(arm_regs[0]);
        m2 = longint'(arm_regs[1]);
        l1 = longint'(arm_regs[2]);
        l2 = longint'(arm_regs[3]);
        mw = longint'(arm_regs[4]);
        rw = longint'(arm_regs[5]);
        g = longint'($signed(arm_regs[6]));
        ang = longint'(it.angle);
        if (ang > 12868) ang -= 25736;
        if (ang < -12868) ang += 25736;
        if (ang > 6434) begin
            ang -= 12868;
            neg = 1'b1;
        end else if (ang < -6434) begin
            ang += 12868;
            neg = 1'b1;
        end
        x = 39797;
        y = 0;
        z = ang * 16;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= AtanTbl[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += AtanTbl[i];
            end
            x = nx;
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
        w1 = longint'(it.w1);
        w2 = longint'(it.w2);
        h = fx_mul(fx_mul(m2, l1, 16, f), l2, 16, f);
        p = fx_mul(fx_mul(m2, l2, 16, f), l2, 16, f);
        q = fx_mul(fx_mul(m1 + m2, l1, 16, f), l1, 16, f);
        hc = fx_mul(h, c, 16, f);
        hs = fx_mul(h, s, 16, f);
        m11 = clip(p + 2 * hc + q, Q32Lo, Q32Hi, f);
        m12 = clip(p + hc, Q32Lo, Q32Hi, f);
        ww11 = fx_mul(w1, w1, 12, f);
        ww12 = fx_mul(w1, w2, 12, f);
        ww22 = fx_mul(w2, w2, 12, f);
        t[0] = fx_mul(m11, longint'(it.a1), 16, f) + fx_mul(m12, longint'(it.a2), 16, f)
             - fx_mul(hs, ww22, 16, f) - 2 * fx_mul(hs, ww12, 16, f);
        t[1] = fx_mul(m12, longint'(it.a1), 16, f) + fx_mul(p, longint'(it.a2), 16, f)
             + fx_mul(hs, ww11, 16, f);
        t[2] = fx_mul(m2, g, 20, f) + fx_mul(m2, longint'(it.al), 16, f);
        t[3] = fx_mul(fx_mul(fx_mul(mw, rw, 16, f), rw, 16, f), longint'(it.aw), 16, f);
        for (int k = 0; k < 4; k++)
            t[k] = clip(t[k], -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1, f);
        r.shoulder = scara_idt_pkg::t_word'(t[0]);
        r.elbow = scara_idt_pkg::t_word'(t[1]);
        r.lift = scara_idt_pkg::t_word'(t[2]);
        r.wrist = scara_idt_pkg::t_word'(t[3]);
        r.sat = f;
        return r;
    endfunction

    function automatic scara_idt_pkg::t_word rand_word();
        case ($urandom_range(3))
            0: return scara_idt_pkg::t_word'($urandom);
            1: return scara_idt_pkg::t_word'(int'($urandom_range(8192)) - 4096);
            2: return scara_idt_pkg::t_word'(int'($urandom_range(1 << 18)) - (1 << 17));
            default: return $urandom_range(1) ? WordMax : WordMin;
        endcase
    endfunction

    function automatic t_arm_item rand_item();
        t_arm_item it;
        if ($urandom_range(4) != 0) it.angle = t_angle'(int'($urandom_range(25736)) - 12868);
        else it.angle = t_angle'($urandom);
        it.w1 = rand_word();
        it.w2 = rand_word();
        it.a1 = rand_word();
        it.a2 = rand_word();
        it.al = rand_word();
        it.aw = rand_word();
        return it;
    endfunction

    task automatic write_reg(logic [scara_idt_pkg::CfgIdxW-1:0] idx,
                             logic [scara_idt_pkg::CfgW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx < NumRegs) arm_regs[idx] = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && expected_torques.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_items.push_back(rand_item());
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) expected_torques.push_back(arm_torques(driven_item));
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven_item = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_elbow_angle <= driven_item.angle;
                    i_shoulder_rate <= driven_item.w1;
                    i_elbow_rate <= driven_item.w2;
                    i_shoulder_accel <= driven_item.a1;
                    i_elbow_accel <= driven_item.a2;
                    i_lift_accel <= driven_item.al;
                    i_wrist_accel <= driven_item.aw;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_torques e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_torques.size() == 0) begin
                    errors++;
                    $display("%0t: result with no item pending: %0d %0d %0d %0d %0b", $time,
                             o_shoulder_torque, o_elbow_torque, o_lift_force, o_wrist_torque,
                             o_saturated);
                end else begin
                    e = expected_torques.pop_front();
                    if (o_shoulder_torque !== e.shoulder) begin
                        errors++;
                        $display("%0t: shoulder_torque expected %0d actual %0d", $time,
                                 e.shoulder, o_shoulder_torque);
                    end
                    if (o_elbow_torque !== e.elbow) begin
                        errors++;
                        $display("%0t: elbow_torque expected %0d actual %0d", $time,
                                 e.elbow, o_elbow_torque);
                    end
                    if (o_lift_force !== e.lift) begin
                        errors++;
                        $display("%0t: lift_force expected %0d actual %0d", $time,
                                 e.lift, o_lift_force);
                    end
                    if (o_wrist_torque !== e.wrist) begin
                        errors++;
                        $display("%0t: wrist_torque expected %0d actual %0d", $time,
                                 e.wrist, o_wrist_torque);
                    end
                    if (o_saturated !== e.sat) begin
                        errors++;
                        $display("%0t: saturated expected %0b actual %0b", $time,
                                 e.sat, o_saturated);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_arm_item it;
        int angles [12];
        angles = '{0, 12868, -12868, 6434, -6434, 6435, -6435, 12869, -12869,
                   16383, -16384, 3217};
        send_idle_pct = 25;
        recv_idle_pct = 58;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_elbow_angle = '0;
        i_shoulder_rate = '0;
        i_elbow_rate = '0;
        i_shoulder_accel = '0;
        i_elbow_accel = '0;
        i_lift_accel = '0;
        i_wrist_accel = '0;
        arm_regs[0] = scara_idt_pkg::CfgRstMassOne;
        arm_regs[1] = scara_idt_pkg::CfgRstMassTwo;
        arm_regs[2] = scara_idt_pkg::CfgRstLenOne;
        arm_regs[3] = scara_idt_pkg::CfgRstLenTwo;
        arm_regs[4] = scara_idt_pkg::CfgRstMassWrist;
        arm_regs[5] = scara_idt_pkg::CfgRstRadWrist;
        arm_regs[6] = scara_idt_pkg::CfgRstGravity;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (angles[k]) begin
            it = '{t_angle'(angles[k]), 24'sd4096, -24'sd8192, 24'sd40960, -24'sd4096,
                   24'sd4096, -24'sd40960};
            pending_items.push_back(it);
        end
        it = '{'0, '0, '0, '0, '0, '0, '0};
        pending_items.push_back(it);
        it = '{t_angle'(6434), WordMax, WordMax, WordMax, WordMax, WordMax, WordMax};
        pending_items.push_back(it);
        it = '{t_angle'(-6434), WordMin, WordMin, WordMin, WordMin, WordMin, WordMin};
        pending_items.push_back(it);
        it = '{t_angle'(1000), WordMin, WordMax, '0, '0, '0, '0};
        pending_items.push_back(it);
        queue_random(190);
        drain();

        write_reg(scara_idt_pkg::CfgMassLinkOne, '1);
        write_reg(scara_idt_pkg::CfgMassLinkTwo, '1);
        write_reg(scara_idt_pkg::CfgLengthLinkOne, '1);
        write_reg(scara_idt_pkg::CfgLengthLinkTwo, '1);
        write_reg(scara_idt_pkg::CfgMassWrist, '1);
        write_reg(scara_idt_pkg::CfgRadiusWrist, '1);
        write_reg(scara_idt_pkg::CfgGravityAccel, 24'h800000);
        write_reg(CfgIdxUnused, 24'h123456);
        queue_random(50);
        drain();

        write_reg(scara_idt_pkg::CfgMassLinkOne, '0);
        write_reg(scara_idt_pkg::CfgMassLinkTwo, '0);
        write_reg(scara_idt_pkg::CfgLengthLinkOne, '0);
        write_reg(scara_idt_pkg::CfgLengthLinkTwo, '0);
        write_reg(scara_idt_pkg::CfgMassWrist, '0);
        write_reg(scara_idt_pkg::CfgRadiusWrist, '0);
        write_reg(scara_idt_pkg::CfgGravityAccel, 24'h7fffff);
        queue_random(50);
        drain();

        send_idle_pct = 58;
        recv_idle_pct = 25;
        write_reg(scara_idt_pkg::CfgMassLinkOne, scara_idt_pkg::CfgW'($urandom_range(8 << 16)));
        write_reg(scara_idt_pkg::CfgMassLinkTwo, scara_idt_pkg::CfgW'($urandom_range(8 << 16)));
        write_reg(scara_idt_pkg::CfgLengthLinkOne,
                  scara_idt_pkg::CfgW'($urandom_range(1 << 16)));
        write_reg(scara_idt_pkg::CfgLengthLinkTwo,
                  scara_idt_pkg::CfgW'($urandom_range(1 << 16)));
        write_reg(scara_idt_pkg::CfgMassWrist, scara_idt_pkg::CfgW'($urandom_range(4 << 16)));
        write_reg(scara_idt_pkg::CfgRadiusWrist, scara_idt_pkg::CfgW'($urandom_range(1 << 14)));
        write_reg(scara_idt_pkg::CfgGravityAccel, scara_idt_pkg::CfgW'($urandom));
        queue_random(180);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(scara_idt_pkg::CfgMassLinkOne, scara_idt_pkg::CfgRstMassOne);
        write_reg(scara_idt_pkg::CfgMassLinkTwo, scara_idt_pkg::CfgRstMassTwo);
        write_reg(scara_idt_pkg::CfgLengthLinkOne, scara_idt_pkg::CfgRstLenOne);
        write_reg(scara_idt_pkg::CfgLengthLinkTwo, scara_idt_pkg::CfgRstLenTwo);
        write_reg(scara_idt_pkg::CfgMassWrist, scara_idt_pkg::CfgRstMassWrist);
        write_reg(scara_idt_pkg::CfgRadiusWrist, scara_idt_pkg::CfgRstRadWrist);
        write_reg(scara_idt_pkg::CfgGravityAccel, scara_idt_pkg::CfgRstGravity);
        queue_random(150);
        drain();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* scara_inverse_dynamics_torque.f */
+incdir+rtl
rtl/scara_idt_pkg.sv
rtl/scara_idt_coef.sv
rtl/scara_idt_cordic.sv
rtl/scara_idt_dyn.sv
rtl/scara_inverse_dynamics_torque.sv
test/testbench.sv
